// ----- rtl/core/hra_pkg.sv -----
// Shared constants, codes and command/status types of the handshake registry.
`default_nettype none
package hra_pkg;

	localparam int PEND_DEPTH = 16;
	localparam int ACT_DEPTH  = 32;
	localparam int LIST_CAP   = 32;

	localparam int PTAB    = 2 * PEND_DEPTH;
	localparam int ATAB    = 2 * ACT_DEPTH;
	localparam int PS_W    = $clog2(PEND_DEPTH);
	localparam int AS_W    = $clog2(ACT_DEPTH);
	localparam int PI_W    = $clog2(PTAB);
	localparam int AI_W    = $clog2(ATAB);
	localparam int IDX_MAX = (PTAB > ATAB) ? PTAB : ATAB;
	localparam int CNT_W   = $clog2(IDX_MAX + 1);

	localparam int ADDR_W = 32;
	localparam int TICK_W = 32;
	localparam int IVL_W  = 16;
	localparam int ML_W   = 6;
	localparam int NUM_W  = 6;
	localparam int CFG_W  = 16;

	localparam logic [IVL_W-1:0] REAP_RST = 16'd930;
	localparam logic [ML_W-1:0]  MAXL_RST = 6'd32;

	localparam logic CFG_REAP = 1'b0;
	localparam logic CFG_MAXL = 1'b1;

	typedef enum logic [2:0] {
		F_KEEPALIVE = 3'd0,
		F_SHAKE     = 3'd1,
		F_TERMINATE = 3'd2,
		F_LIST      = 3'd3,
		F_TICK      = 3'd4
	} func_t;

	typedef enum logic [3:0] {
		K_HANDSHAKE  = 4'd0,
		K_LIST_HDR   = 4'd1,
		K_LIST_ADDR  = 4'd2,
		K_RANGE_ERR  = 4'd3,
		K_REJECTED   = 4'd4,
		K_ADDED      = 4'd5,
		K_REFRESHED  = 4'd6,
		K_TERMINATED = 4'd7,
		K_UNLISTED   = 4'd8,
		K_FULL       = 4'd9
	} kind_t;

	typedef enum logic [2:0] {
		SM_PNONCE  = 3'd0,
		SM_PFREE   = 3'd1,
		SM_AADDR   = 3'd2,
		SM_AFREE   = 3'd3,
		SM_COUNT   = 3'd4,
		SM_SWEEP_P = 3'd5,
		SM_SWEEP_A = 3'd6
	} scan_t;

	typedef enum logic [1:0] {
		FMT_PLAIN = 2'd0,
		FMT_TOKEN = 2'd1,
		FMT_HDR   = 2'd2,
		FMT_ADDR  = 2'd3
	} fmt_t;

	typedef enum logic [2:0] {
		ACT_NONE = 3'd0,
		ACT_PWR  = 3'd1,
		ACT_ANEW = 3'd2,
		ACT_AREF = 3'd3,
		ACT_ACLR = 3'd4
	} act_t;

	typedef struct packed {
		logic  capture;
		logic  scan_start;
		scan_t scan_mode;
		logic  set_hit0;
		logic  p_clr;
		act_t  act;
		logic  tick;
		logic  em_init;
		logic  em_step;
		logic  out_load;
		kind_t out_kind;
		fmt_t  out_fmt;
	} hra_cmd_t;

	typedef struct packed {
		func_t func;
		logic  start_zero;
		logic  done;
		logic  hit;
		logic  found;
		logic  total_zero;
		logic  packed_zero;
		logic  em_valid;
		logic  em_last;
		logic  out_free;
		logic  sweep_need;
	} hra_stat_t;

endpackage
`default_nettype wire

// ----- rtl/core/hra_dp.sv -----
// Datapath: tables, valid bits, slot scanner, time base and result register.
`default_nettype none
module hra_dp
	import hra_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire hra_cmd_t          cmd,
	output hra_stat_t              st,
	input  wire logic [2:0]        func,
	input  wire logic              is_client,
	input  wire logic [ADDR_W-1:0] src_addr,
	input  wire logic [ADDR_W-1:0] token,
	input  wire logic [ADDR_W-1:0] start_addr,
	input  wire logic              cfg_we,
	input  wire logic              cfg_index,
	input  wire logic [CFG_W-1:0]  cfg_data,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [3:0]             kind,
	output logic [ADDR_W-1:0]      value,
	output logic [NUM_W-1:0]       total,
	output logic [NUM_W-1:0]       packed_res,
	output logic                   last
);

	func_t             func_q;
	logic              role_q;
	logic [ADDR_W-1:0] src_q;
	logic [ADDR_W-1:0] token_q;
	logic [ADDR_W-1:0] start_q;

	logic [IVL_W-1:0]  interval_q;
	logic [ML_W-1:0]   maxl_q;
	logic [TICK_W-1:0] now_q;
	logic [IVL_W-1:0]  sweep_q;

	logic [PTAB-1:0]   pvalid_q;
	logic [ATAB-1:0]   avalid_q;

	logic [ADDR_W-1:0] p_nonce_mem [PTAB];
	logic [TICK_W-1:0] p_stamp_mem [PTAB];
	logic [ADDR_W-1:0] a_addr_mem  [ATAB];
	logic [TICK_W-1:0] a_stamp_mem [ATAB];
	logic [ADDR_W-1:0] p_nonce_rd_q;
	logic [TICK_W-1:0] p_stamp_rd_q;
	logic [ADDR_W-1:0] a_addr_rd_q;
	logic [TICK_W-1:0] a_stamp_rd_q;

	logic              scan_on_q;
	scan_t             mode_q;
	logic [CNT_W-1:0]  idx_q;
	logic              vld_s1;
	logic [CNT_W-1:0]  idx_s1;
	logic              found_q;
	logic [CNT_W-1:0]  hit_idx_q;
	logic [NUM_W-1:0]  total_q;
	logic [NUM_W-1:0]  pk_q;
	logic [NUM_W-1:0]  em_cnt_q;

	logic              out_valid_q;
	kind_t             kind_q;
	logic [ADDR_W-1:0] value_q;
	logic [NUM_W-1:0]  total_o_q;
	logic [NUM_W-1:0]  pk_o_q;
	logic              last_q;

	logic              arole;
	logic [ADDR_W-1:0] key;
	logic [PI_W-1:0]   p_raddr, p_waddr, p_sidx;
	logic [AI_W-1:0]   a_raddr, a_waddr, a_sidx;
	logic [CNT_W-1:0]  lim;
	logic              issue_more;
	logic              pv_s1, av_s1, p_stale, a_stale;
	logic              match;
	logic              hit_mode;
	logic              hit_now;
	logic              done;
	logic [IVL_W-1:0]  sweep_new;
	logic              sweep_need;
	logic [NUM_W-1:0]  list_lim;
	logic              em_last;
	logic              out_free;

	function automatic logic [PI_W-1:0] p_flat(input logic [CNT_W-1:0] i);
		if (mode_q == SM_SWEEP_P)
			return i[PI_W-1:0];
		return {role_q, i[PS_W-1:0]};
	endfunction

	function automatic logic [AI_W-1:0] a_flat(input logic [CNT_W-1:0] i);
		if (mode_q == SM_SWEEP_A)
			return i[AI_W-1:0];
		return {arole, i[AS_W-1:0]};
	endfunction

	assign arole   = (func_q == F_SHAKE) ? role_q : 1'b0;
	assign key     = (func_q == F_LIST) ? start_q : src_q;

	always_comb begin
		p_raddr = p_flat(idx_q);
		a_raddr = a_flat(idx_q);
		p_sidx  = p_flat(idx_s1);
		a_sidx  = a_flat(idx_s1);
	end

	assign p_waddr = {role_q, hit_idx_q[PS_W-1:0]};
	assign a_waddr = {arole, hit_idx_q[AS_W-1:0]};

	assign pv_s1   = pvalid_q[p_sidx];
	assign av_s1   = avalid_q[a_sidx];
	assign p_stale = (now_q - p_stamp_rd_q) > {{(TICK_W-IVL_W){1'b0}}, interval_q};
	assign a_stale = (now_q - a_stamp_rd_q) > {{(TICK_W-IVL_W){1'b0}}, interval_q};

	always_comb begin
		lim      = CNT_W'(ACT_DEPTH);
		match    = 1'b0;
		hit_mode = 1'b0;
		case (mode_q)
			SM_PNONCE: begin
				lim      = CNT_W'(PEND_DEPTH);
				match    = pv_s1 && (p_nonce_rd_q == token_q);
				hit_mode = 1'b1;
			end
			SM_PFREE: begin
				lim      = CNT_W'(PEND_DEPTH);
				match    = !pv_s1;
				hit_mode = 1'b1;
			end
			SM_AADDR: begin
				match    = av_s1 && (a_addr_rd_q == key);
				hit_mode = 1'b1;
			end
			SM_AFREE: begin
				match    = !av_s1;
				hit_mode = 1'b1;
			end
			SM_SWEEP_P: lim = CNT_W'(PTAB);
			SM_SWEEP_A: lim = CNT_W'(ATAB);
			default: lim = CNT_W'(ACT_DEPTH);
		endcase
	end

	assign issue_more = idx_q < lim;
	assign hit_now    = scan_on_q && hit_mode && vld_s1 && match;
	assign done       = scan_on_q && (hit_now || (!vld_s1 && !issue_more));
	assign sweep_new  = sweep_q + 1'b1;
	assign sweep_need = sweep_new >= interval_q;
	assign list_lim   = (maxl_q > NUM_W'(LIST_CAP)) ? NUM_W'(LIST_CAP) : maxl_q;
	assign em_last    = (em_cnt_q + 1'b1) == pk_q;
	assign out_free   = !out_valid_q || !out_stall;

	always_comb begin
		st.func        = func_q;
		st.start_zero  = start_q == '0;
		st.done        = done;
		st.hit         = hit_now;
		st.found       = found_q;
		st.total_zero  = total_q == '0;
		st.packed_zero = pk_q == '0;
		st.em_valid    = avalid_q[a_raddr];
		st.em_last     = em_last;
		st.out_free    = out_free;
		st.sweep_need  = sweep_need;
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q  <= func_t'(func);
			role_q  <= is_client;
			src_q   <= src_addr;
			token_q <= token;
			start_q <= start_addr;
		end
		idx_s1 <= idx_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.act == ACT_PWR) begin
			p_nonce_mem[p_waddr] <= token_q;
			p_stamp_mem[p_waddr] <= now_q;
		end
		p_nonce_rd_q <= p_nonce_mem[p_raddr];
		p_stamp_rd_q <= p_stamp_mem[p_raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.act == ACT_ANEW)
			a_addr_mem[a_waddr] <= src_q;
		if (cmd.act == ACT_ANEW || cmd.act == ACT_AREF)
			a_stamp_mem[a_waddr] <= now_q;
		a_addr_rd_q  <= a_addr_mem[a_raddr];
		a_stamp_rd_q <= a_stamp_mem[a_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= REAP_RST;
			maxl_q     <= MAXL_RST;
			now_q      <= '0;
			sweep_q    <= '0;
			pvalid_q   <= '0;
			avalid_q   <= '0;
			scan_on_q  <= 1'b0;
			mode_q     <= SM_PNONCE;
			idx_q      <= '0;
			vld_s1     <= 1'b0;
			found_q    <= 1'b0;
			hit_idx_q  <= '0;
			total_q    <= '0;
			pk_q       <= '0;
			em_cnt_q   <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_REAP: interval_q <= cfg_data;
					CFG_MAXL: maxl_q     <= cfg_data[ML_W-1:0];
					default: ;
				endcase
			end
			if (cmd.tick) begin
				now_q   <= now_q + 1'b1;
				sweep_q <= sweep_need ? '0 : sweep_new;
			end
			if (cmd.set_hit0) begin
				found_q   <= 1'b1;
				hit_idx_q <= '0;
			end
			if (scan_on_q && done && hit_mode) begin
				found_q <= hit_now;
				if (hit_now)
					hit_idx_q <= idx_s1;
			end
			if (cmd.scan_start) begin
				scan_on_q <= 1'b1;
				mode_q    <= cmd.scan_mode;
				idx_q     <= '0;
				vld_s1    <= 1'b0;
				if (cmd.scan_mode == SM_COUNT) begin
					total_q <= '0;
					pk_q    <= '0;
				end
			end else if (scan_on_q) begin
				if (done) begin
					scan_on_q <= 1'b0;
					vld_s1    <= 1'b0;
				end else begin
					vld_s1 <= issue_more;
					if (issue_more)
						idx_q <= idx_q + 1'b1;
				end
				if (vld_s1) begin
					case (mode_q)
						SM_COUNT: begin
							if (av_s1) begin
								total_q <= total_q + 1'b1;
								if (idx_s1 >= hit_idx_q && pk_q < list_lim)
									pk_q <= pk_q + 1'b1;
							end
						end
						SM_SWEEP_P: if (pv_s1 && p_stale) pvalid_q[p_sidx] <= 1'b0;
						SM_SWEEP_A: if (av_s1 && a_stale) avalid_q[a_sidx] <= 1'b0;
						default: ;
					endcase
				end
			end else if (cmd.em_init) begin
				idx_q    <= hit_idx_q;
				em_cnt_q <= '0;
			end else if (cmd.em_step) begin
				idx_q <= idx_q + 1'b1;
				if (cmd.out_load)
					em_cnt_q <= em_cnt_q + 1'b1;
			end
			if (cmd.p_clr)
				pvalid_q[p_waddr] <= 1'b0;
			case (cmd.act)
				ACT_PWR:  pvalid_q[p_waddr] <= 1'b1;
				ACT_ANEW: avalid_q[a_waddr] <= 1'b1;
				ACT_ACLR: avalid_q[a_waddr] <= 1'b0;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			kind_q    <= cmd.out_kind;
			value_q   <= '0;
			total_o_q <= '0;
			pk_o_q    <= '0;
			last_q    <= 1'b1;
			case (cmd.out_fmt)
				FMT_TOKEN: value_q <= token_q;
				FMT_HDR: begin
					total_o_q <= total_q;
					pk_o_q    <= pk_q;
					last_q    <= pk_q == '0;
				end
				FMT_ADDR: begin
					value_q <= a_addr_rd_q;
					last_q  <= em_last;
				end
				default: ;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign kind       = kind_q;
	assign value      = value_q;
	assign total      = total_o_q;
	assign packed_res = pk_o_q;
	assign last       = last_q;

endmodule
`default_nettype wire

// ----- rtl/core/hra_ctrl.sv -----
// Controller: sequences scans, table updates and result emission per request.
`default_nettype none
module hra_ctrl
	import hra_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_stall,
	output hra_cmd_t       cmd,
	input  wire hra_stat_t st
);

	typedef enum logic [15:0] {
		S_IDLE  = 16'h0001,
		S_DISP  = 16'h0002,
		S_KA    = 16'h0004,
		S_SHP   = 16'h0008,
		S_SHCLR = 16'h0010,
		S_SHA   = 16'h0020,
		S_SHF   = 16'h0040,
		S_TM    = 16'h0080,
		S_LSF   = 16'h0100,
		S_LSC   = 16'h0200,
		S_LSH   = 16'h0400,
		S_EMRD  = 16'h0800,
		S_EMCHK = 16'h1000,
		S_SWP   = 16'h2000,
		S_SWA   = 16'h4000,
		S_EMIT  = 16'h8000
	} state_t;

	state_t state_q, state_d;
	kind_t  res_kind_q, res_kind_d;
	fmt_t   res_fmt_q, res_fmt_d;
	act_t   act_q, act_d;

	always_comb begin
		cmd        = '0;
		in_stall   = 1'b1;
		state_d    = state_q;
		res_kind_d = res_kind_q;
		res_fmt_d  = res_fmt_q;
		act_d      = act_q;
		unique case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DISP;
				end
			end
			S_DISP: begin
				unique case (st.func)
					F_KEEPALIVE: begin
						cmd.scan_start = 1'b1;
						cmd.scan_mode  = SM_PFREE;
						state_d        = S_KA;
					end
					F_SHAKE: begin
						cmd.scan_start = 1'b1;
						cmd.scan_mode  = SM_PNONCE;
						state_d        = S_SHP;
					end
					F_TERMINATE: begin
						cmd.scan_start = 1'b1;
						cmd.scan_mode  = SM_AADDR;
						state_d        = S_TM;
					end
					F_LIST: begin
						cmd.scan_start = 1'b1;
						if (st.start_zero) begin
							cmd.set_hit0  = 1'b1;
							cmd.scan_mode = SM_COUNT;
							state_d       = S_LSC;
						end else begin
							cmd.scan_mode = SM_AADDR;
							state_d       = S_LSF;
						end
					end
					F_TICK: begin
						cmd.tick = 1'b1;
						if (st.sweep_need) begin
							cmd.scan_start = 1'b1;
							cmd.scan_mode  = SM_SWEEP_P;
							state_d        = S_SWP;
						end else begin
							state_d = S_IDLE;
						end
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_KA: begin
				if (st.done) begin
					res_kind_d = st.hit ? K_HANDSHAKE : K_FULL;
					res_fmt_d  = st.hit ? FMT_TOKEN : FMT_PLAIN;
					act_d      = st.hit ? ACT_PWR : ACT_NONE;
					state_d    = S_EMIT;
				end
			end
			S_SHP: begin
				if (st.done) begin
					if (st.hit) begin
						state_d = S_SHCLR;
					end else begin
						res_kind_d = K_REJECTED;
						res_fmt_d  = FMT_PLAIN;
						act_d      = ACT_NONE;
						state_d    = S_EMIT;
					end
				end
			end
			S_SHCLR: begin
				cmd.p_clr      = 1'b1;
				cmd.scan_start = 1'b1;
				cmd.scan_mode  = SM_AADDR;
				state_d        = S_SHA;
			end
			S_SHA: begin
				if (st.done) begin
					if (st.hit) begin
						res_kind_d = K_REFRESHED;
						res_fmt_d  = FMT_PLAIN;
						act_d      = ACT_AREF;
						state_d    = S_EMIT;
					end else begin
						cmd.scan_start = 1'b1;
						cmd.scan_mode  = SM_AFREE;
						state_d        = S_SHF;
					end
				end
			end
			S_SHF: begin
				if (st.done) begin
					res_kind_d = st.hit ? K_ADDED : K_FULL;
					res_fmt_d  = FMT_PLAIN;
					act_d      = st.hit ? ACT_ANEW : ACT_NONE;
					state_d    = S_EMIT;
				end
			end
			S_TM: begin
				if (st.done) begin
					res_kind_d = st.hit ? K_TERMINATED : K_UNLISTED;
					res_fmt_d  = FMT_PLAIN;
					act_d      = st.hit ? ACT_ACLR : ACT_NONE;
					state_d    = S_EMIT;
				end
			end
			S_LSF: begin
				if (st.done) begin
					cmd.scan_start = 1'b1;
					cmd.scan_mode  = SM_COUNT;
					state_d        = S_LSC;
				end
			end
			S_LSC: begin
				if (st.done)
					state_d = S_LSH;
			end
			S_LSH: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					if (st.found) begin
						cmd.out_kind = K_LIST_HDR;
						cmd.out_fmt  = FMT_HDR;
						if (st.packed_zero) begin
							state_d = S_IDLE;
						end else begin
							cmd.em_init = 1'b1;
							state_d     = S_EMRD;
						end
					end else begin
						cmd.out_kind = st.total_zero ? K_LIST_HDR : K_RANGE_ERR;
						cmd.out_fmt  = FMT_PLAIN;
						state_d      = S_IDLE;
					end
				end
			end
			S_EMRD: state_d = S_EMCHK;
			S_EMCHK: begin
				if (!st.em_valid) begin
					cmd.em_step = 1'b1;
					state_d     = S_EMRD;
				end else if (st.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_kind = K_LIST_ADDR;
					cmd.out_fmt  = FMT_ADDR;
					cmd.em_step  = 1'b1;
					state_d      = st.em_last ? S_IDLE : S_EMRD;
				end
			end
			S_SWP: begin
				if (st.done) begin
					cmd.scan_start = 1'b1;
					cmd.scan_mode  = SM_SWEEP_A;
					state_d        = S_SWA;
				end
			end
			S_SWA: begin
				if (st.done)
					state_d = S_IDLE;
			end
			S_EMIT: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_kind = res_kind_q;
					cmd.out_fmt  = res_fmt_q;
					cmd.act      = act_q;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			res_kind_q <= K_HANDSHAKE;
			res_fmt_q  <= FMT_PLAIN;
			act_q      <= ACT_NONE;
		end else begin
			state_q    <= state_d;
			res_kind_q <= res_kind_d;
			res_fmt_q  <= res_fmt_d;
			act_q      <= act_d;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/handshake_registry_with_aging.sv -----
// Top level of the handshake registry: controller plus datapath.
// Usage:
//   Requests enter on in_valid/in_stall with func, is_client, src_addr, token
//   and start_addr; a request is taken when in_valid is high and in_stall low.
//   Results leave on out_valid/out_stall with kind, value, total, packed_res
//   and last; last marks the final result of a request.
//   One request is processed at a time. Table lookups walk one slot per cycle.
//   Keepalive walks its half of the pending table for a free slot. Shake
//   walks it for the nonce, then the active table for the address and, if
//   not found, for a free slot. Terminate walks the active table. A list
//   header comes after an optional address walk and a count pass; the
//   addresses follow slot by slot. A tick ends the cycle after it is taken
//   unless it sweeps. The next request is taken the cycle after the last ends.
//   A finished result waits in the output register while the next request is
//   taken; a stalled receiver holds the result and the block waits before
//   emitting another one.
//   Reset clears all table valid bits, time and sweep counters, and loads
//   the sweep period 930 and the list limit 32; no clearing pass is needed.
//   cfg_we writes cfg_data to register cfg_index (0 sweep period, 1 list
//   limit). Users must write only while the block is idle; it is not enforced.
`default_nettype none
module handshake_registry_with_aging
	import hra_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [2:0]        func,
	input  wire logic              is_client,
	input  wire logic [ADDR_W-1:0] src_addr,
	input  wire logic [ADDR_W-1:0] token,
	input  wire logic [ADDR_W-1:0] start_addr,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [3:0]             kind,
	output logic [ADDR_W-1:0]      value,
	output logic [NUM_W-1:0]       total,
	output logic [NUM_W-1:0]       packed_res,
	output logic                   last,
	input  wire logic              cfg_we,
	input  wire logic              cfg_index,
	input  wire logic [CFG_W-1:0]  cfg_data
);

	hra_cmd_t  cmd;
	hra_stat_t st;

	hra_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.st       (st)
	);

	hra_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.st         (st),
		.func       (func),
		.is_client  (is_client),
		.src_addr   (src_addr),
		.token      (token),
		.start_addr (start_addr),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.kind       (kind),
		.value      (value),
		.total      (total),
		.packed_res (packed_res),
		.last       (last)
	);

endmodule
`default_nettype wire

// ----- test/handshake_registry_with_aging_tb.sv -----
// Testbench for the handshake registry: directed and random requests checked against a predictor.
`timescale 1ns / 100ps
module handshake_registry_with_aging_tb;
	import hra_pkg::*;

	localparam int WATCH_LIMIT = 20000;

	typedef struct {
		kind_t       kind;
		logic [31:0] value;
		logic [5:0]  total;
		logic [5:0]  pk;
		logic        last;
	} reply_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  func = 3'd0;
	logic        is_client = 1'b0;
	logic [31:0] src_addr = 32'd0;
	logic [31:0] token = 32'd0;
	logic [31:0] start_addr = 32'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [3:0]  kind;
	logic [31:0] value;
	logic [5:0]  total;
	logic [5:0]  packed_res;
	logic        last;
	logic        cfg_we = 1'b0;
	logic        cfg_index = 1'b0;
	logic [15:0] cfg_data = 16'd0;

	handshake_registry_with_aging DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.func(func), .is_client(is_client), .src_addr(src_addr),
		.token(token), .start_addr(start_addr),
		.out_valid(out_valid), .out_stall(out_stall),
		.kind(kind), .value(value), .total(total), .packed_res(packed_res), .last(last),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor state
	logic [15:0] reap_ivl = REAP_RST;
	logic [5:0]  list_max = MAXL_RST;
	logic [31:0] ticks_now = 0;
	logic [15:0] sweep_cnt = 0;
	logic [31:0] pend_addr [PTAB];
	logic [31:0] pend_nonce [PTAB];
	logic [31:0] pend_stamp [PTAB];
	logic        pend_val [PTAB];
	logic [31:0] act_addr [ATAB];
	logic [31:0] act_stamp [ATAB];
	logic        act_val [ATAB];

	reply_t      replies_due [$];
	logic [31:0] nonce_pool [$];
	int          err_cnt = 0;
	int          idle_cycles = 0;
	int          send_idle = 0;
	int          recv_stall = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		foreach (pend_val[i]) pend_val[i] = 1'b0;
		foreach (act_val[i]) act_val[i] = 1'b0;
	end

	function automatic void push_reply(kind_t k, logic [31:0] v, logic [5:0] t);
		reply_t r;
		r.kind = k; r.value = v; r.total = t; r.pk = 0; r.last = 1'b0;
		replies_due.push_back(r);
	endfunction

	function automatic int find_act(int base, logic [31:0] a);
		for (int s = 0; s < ACT_DEPTH; s++)
			if (act_val[base + s] && act_addr[base + s] == a) return base + s;
		return -1;
	endfunction

	function automatic void predict_request(logic [2:0] f, logic cl, logic [31:0] src,
			logic [31:0] tok, logic [31:0] st);
		int pb, ab, hit, first, hdr, cnt, lim;
		logic [5:0] tot;
		pb = cl ? PEND_DEPTH : 0;
		ab = cl ? ACT_DEPTH : 0;
		first = replies_due.size();
		hit = -1;
		case (f)
			F_KEEPALIVE: begin
				for (int s = 0; s < PEND_DEPTH && hit < 0; s++)
					if (!pend_val[pb + s]) hit = pb + s;
				if (hit < 0) push_reply(K_FULL, 0, 0);
				else begin
					pend_val[hit] = 1'b1; pend_addr[hit] = src;
					pend_nonce[hit] = tok; pend_stamp[hit] = ticks_now;
					push_reply(K_HANDSHAKE, tok, 0);
				end
			end
			F_SHAKE: begin
				for (int s = 0; s < PEND_DEPTH && hit < 0; s++)
					if (pend_val[pb + s] && pend_nonce[pb + s] == tok) hit = pb + s;
				if (hit < 0) push_reply(K_REJECTED, 0, 0);
				else begin
					pend_val[hit] = 1'b0;
					hit = find_act(ab, src);
					if (hit >= 0) begin
						act_stamp[hit] = ticks_now;
						push_reply(K_REFRESHED, 0, 0);
					end else begin
						for (int s = 0; s < ACT_DEPTH && hit < 0; s++)
							if (!act_val[ab + s]) hit = ab + s;
						if (hit < 0) push_reply(K_FULL, 0, 0);
						else begin
							act_val[hit] = 1'b1; act_addr[hit] = src;
							act_stamp[hit] = ticks_now;
							push_reply(K_ADDED, 0, 0);
						end
					end
				end
			end
			F_TERMINATE: begin
				hit = find_act(0, src);
				if (hit >= 0) begin
					act_val[hit] = 1'b0;
					push_reply(K_TERMINATED, 0, 0);
				end else push_reply(K_UNLISTED, 0, 0);
			end
			F_LIST: begin
				tot = 0;
				for (int s = 0; s < ACT_DEPTH; s++) if (act_val[s]) tot++;
				hit = (st == 0) ? 0 : find_act(0, st);
				if (hit < 0) begin
					if (tot == 0) push_reply(K_LIST_HDR, 0, 0);
					else push_reply(K_RANGE_ERR, 0, 0);
				end else begin
					lim = (list_max > LIST_CAP) ? LIST_CAP : list_max;
					hdr = replies_due.size();
					push_reply(K_LIST_HDR, 0, tot);
					cnt = 0;
					for (int s = hit; s < ACT_DEPTH && cnt < lim; s++)
						if (act_val[s]) begin
							push_reply(K_LIST_ADDR, act_addr[s], 0);
							cnt++;
						end
					replies_due[hdr].pk = 6'(cnt);
				end
			end
			F_TICK: begin
				ticks_now++;
				sweep_cnt++;
				if (sweep_cnt >= reap_ivl) begin
					sweep_cnt = 0;
					for (int s = 0; s < PTAB; s++)
						if (pend_val[s] && (ticks_now - pend_stamp[s]) > reap_ivl)
							pend_val[s] = 1'b0;
					for (int s = 0; s < ATAB; s++)
						if (act_val[s] && (ticks_now - act_stamp[s]) > reap_ivl)
							act_val[s] = 1'b0;
				end
			end
			default: ;
		endcase
		if (replies_due.size() > first) replies_due[replies_due.size() - 1].last = 1'b1;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
		err_cnt++;
	endtask

	// monitor, result check and watchdog
	always @(posedge clk) begin
		reply_t r;
		if (arst_n) begin
			idle_cycles++;
			if (in_valid && !in_stall) begin
				idle_cycles = 0;
				predict_request(func, is_client, src_addr, token, start_addr);
			end
			if (out_valid && !out_stall) begin
				idle_cycles = 0;
				if (replies_due.size() == 0)
					report_mismatch("unexpected result", 32'(kind), 32'd0);
				else begin
					r = replies_due.pop_front();
					if (kind != r.kind) report_mismatch("kind", 32'(kind), 32'(r.kind));
					if (value != r.value) report_mismatch("value", value, r.value);
					if (total != r.total) report_mismatch("total", 32'(total), 32'(r.total));
					if (packed_res != r.pk)
						report_mismatch("packed_res", 32'(packed_res), 32'(r.pk));
					if (last != r.last) report_mismatch("last", 32'(last), 32'(r.last));
				end
			end
			if (idle_cycles >= WATCH_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	always @(posedge clk) out_stall <= ($urandom_range(99) < recv_stall);

	task automatic send_req(logic [2:0] f, logic cl, logic [31:0] src, logic [31:0] tok,
			logic [31:0] st);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f; is_client <= cl; src_addr <= src; token <= tok; start_addr <= st;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (f == F_KEEPALIVE) nonce_pool.push_back(tok);
		if (nonce_pool.size() > 24) void'(nonce_pool.pop_front());
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (replies_due.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	task automatic set_reg(logic idx, logic [15:0] data);
		drain();
		cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_REAP) reap_ivl = data;
		else list_max = data[5:0];
	endtask

	task automatic test_keepalive_shake();
		send_req(F_LIST, 0, 0, 0, 0);
		send_req(F_KEEPALIVE, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
		send_req(F_KEEPALIVE, 1, 32'h0, 32'h0, 32'hFFFF_FFFF);
		send_req(F_SHAKE, 0, 32'hAAAA_5555, 32'hFFFF_FFFF, 0);
		send_req(F_SHAKE, 0, 32'h1, 32'hFFFF_FFFF, 0);
		send_req(F_KEEPALIVE, 0, 32'h1, 32'h1234, 0);
		send_req(F_SHAKE, 0, 32'hAAAA_5555, 32'h1234, 0);
		send_req(F_SHAKE, 1, 32'h0, 32'h0, 0);
		send_req(3'd7, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_req(3'd5, 0, 0, 0, 0);
	endtask

	task automatic test_pending_full();
		for (int i = 0; i <= PEND_DEPTH; i++) send_req(F_KEEPALIVE, 1, i, 32'h100 + i, 0);
	endtask

	task automatic test_terminate_list();
		send_req(F_TERMINATE, 1, 32'hAAAA_5555, 0, 0);
		send_req(F_TERMINATE, 0, 32'h5555_AAAA, 0, 0);
		send_req(F_LIST, 0, 0, 0, 32'h1);
		send_req(F_LIST, 0, 0, 0, 32'hDEAD_BEEF);
		set_reg(CFG_MAXL, 16'd0);
		send_req(F_LIST, 0, 0, 0, 0);
		set_reg(CFG_MAXL, 16'd1);
		send_req(F_LIST, 0, 0, 0, 0);
		set_reg(CFG_MAXL, 16'hFFFF);
		send_req(F_LIST, 0, 0, 0, 0);
	endtask

	task automatic test_active_full();
		for (int i = 0; i <= ACT_DEPTH; i++) begin
			send_req(F_KEEPALIVE, 0, 32'h200 + i, 32'h9000 + i, 0);
			send_req(F_SHAKE, 0, 32'h200 + i, 32'h9000 + i, 0);
		end
		send_req(F_LIST, 0, 0, 0, 32'h210);
	endtask

	task automatic test_aging();
		set_reg(CFG_REAP, 16'd2);
		send_req(F_KEEPALIVE, 0, 32'h77, 32'h55, 0);
		repeat (4) send_req(F_TICK, 0, 0, 0, 0);
		send_req(F_SHAKE, 0, 32'h77, 32'h55, 0);
		send_req(F_LIST, 0, 0, 0, 0);
		set_reg(CFG_REAP, 16'd0);
		send_req(F_KEEPALIVE, 1, 32'h78, 32'h56, 0);
		send_req(F_TICK, 0, 0, 0, 0);
		send_req(F_SHAKE, 1, 32'h78, 32'h56, 0);
		set_reg(CFG_REAP, 16'hFFFF);
		send_req(F_TICK, 0, 0, 0, 0);
	endtask

	function automatic logic [31:0] pick_addr();
		return ($urandom_range(19) == 0) ? $urandom : $urandom_range(1, 40);
	endfunction

	task automatic test_random(int n);
		int w;
		logic [31:0] tok, st;
		for (int i = 0; i < n; i++) begin
			w = $urandom_range(99);
			tok = $urandom;
			if (nonce_pool.size() > 0 && $urandom_range(3) != 0)
				tok = nonce_pool[$urandom_range(nonce_pool.size() - 1)];
			st = ($urandom_range(4) < 2) ? 32'd0 : ($urandom_range(4) < 4 ? pick_addr() : $urandom);
			if (w < 25)
				send_req(F_KEEPALIVE, 1'($urandom_range(1)), pick_addr(), $urandom, st);
			else if (w < 52)
				send_req(F_SHAKE, 1'($urandom_range(1)), pick_addr(), tok, st);
			else if (w < 62)
				send_req(F_TERMINATE, 1'($urandom_range(1)), pick_addr(), tok, st);
			else if (w < 75)
				send_req(F_LIST, 1'($urandom_range(1)), pick_addr(), tok, st);
			else if (w < 97)
				send_req(F_TICK, 1'($urandom_range(1)), $urandom, $urandom, st);
			else
				send_req(3'($urandom_range(5, 7)), 1'($urandom_range(1)), $urandom,
					$urandom, $urandom);
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_keepalive_shake();
		test_pending_full();
		test_terminate_list();
		test_active_full();
		test_aging();
		set_reg(CFG_REAP, 16'd1);
		set_reg(CFG_MAXL, 16'd32);
		send_idle = 0; recv_stall = 0;
		test_random(60);
		set_reg(CFG_REAP, 16'd8);
		set_reg(CFG_MAXL, 16'd3);
		send_idle = 74; recv_stall = 0;
		test_random(60);
		set_reg(CFG_REAP, 16'd930);
		set_reg(CFG_MAXL, 16'd63);
		send_idle = 0; recv_stall = 74;
		test_random(60);
		set_reg(CFG_REAP, 16'd20);
		set_reg(CFG_MAXL, 16'd1);
		send_idle = 11; recv_stall = 11;
		test_random(60);
		drain();
		if (err_cnt == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/hra_pkg.sv
rtl/core/hra_dp.sv
rtl/core/hra_ctrl.sv
rtl/core/handshake_registry_with_aging.sv
test/handshake_registry_with_aging_tb.sv
